// ===== src/q2k_pkg.sv =====
package q2k_pkg;

    localparam int ELEMS     = 16;
    localparam int WCODE_W   = 2;
    localparam int ACT_W     = 8;
    localparam int NIB_W     = 4;
    localparam int SM_W      = 8;
    localparam int GS_W      = 12;
    localparam int DOT_W     = 14;
    localparam int SCALED_W  = 18;
    localparam int MINP_W    = 16;
    localparam int MAIN_W    = 22;
    localparam int MIN_W     = 20;
    localparam int LANES_DEF = 4;

    typedef struct packed {
        logic valid;
        logic last;
    } q2k_ctl_t;

endpackage

// ===== src/q2k_in_if.sv =====
interface q2k_in_if;
    import q2k_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [ELEMS*WCODE_W-1:0]   weight_codes;
    logic [64-1:0]              acts_low;
    logic [64-1:0]              acts_high;
    logic [SM_W-1:0]            scale_min;
    logic signed [GS_W-1:0]     group_sum;
    logic                       last;

    modport source (
        output valid, weight_codes, acts_low, acts_high, scale_min, group_sum, last,
        input  ready
    );

    modport sink (
        input  valid, weight_codes, acts_low, acts_high, scale_min, group_sum, last,
        output ready
    );
endinterface

// ===== src/q2k_out_if.sv =====
interface q2k_out_if;
    import q2k_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [MAIN_W-1:0]   main_sum;
    logic signed [MIN_W-1:0]    min_sum;

    modport source (
        output valid, main_sum, min_sum,
        input  ready
    );

    modport sink (
        input  valid, main_sum, min_sum,
        output ready
    );
endinterface

// ===== src/q2k_q8k_block_dot.sv =====
// Takes one 16-element sub-block a cycle while input ready is high. The elements
// split over LANES lanes (1, 2, 4, 8 or 16), each summing weight times activation
// for its share; a merge stage adds the lanes and multiplies by the sub-block
// scale, and min by group sum, and the accumulator adds both with saturation. A
// sub-block marked last passes the lane and merge registers into the result
// registers, and the sums restart from zero. Input ready drops only while a last
// sub-block sits at the accumulator and the previous result has not yet been taken.
module q2k_q8k_block_dot #(
    parameter int LANES = q2k_pkg::LANES_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    q2k_in_if.sink    sub_block,
    q2k_out_if.source result
);
    import q2k_pkg::*;

    localparam int EPL    = ELEMS / LANES;
    localparam int PART_W = ACT_W + 2 + $clog2(EPL);

    logic                       adv;
    logic [2*64-1:0]            acts_all;
    logic signed [PART_W-1:0]   part [LANES];
    logic [SM_W-1:0]            s1_sm_reg;
    logic signed [GS_W-1:0]     s1_gs_reg;
    q2k_ctl_t                   s1_ctl_reg;
    q2k_ctl_t                   s2_ctl;
    logic signed [SCALED_W-1:0] scaled;
    logic signed [MINP_W-1:0]   min_prod;

    assign acts_all        = {sub_block.acts_high, sub_block.acts_low};
    assign sub_block.ready = adv;

    for (genvar l = 0; l < LANES; l++)
    begin : g_lane
        q2k_lane #(
            .EPL (EPL)
        ) u_lane (
            .clk     (clk),
            .en      (adv),
            .weights (sub_block.weight_codes[EPL*WCODE_W*l +: EPL*WCODE_W]),
            .acts    (acts_all[EPL*ACT_W*l +: EPL*ACT_W]),
            .part    (part[l])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_ctl_reg <= '0;
        end
        else if (adv)
        begin
            s1_ctl_reg.valid <= sub_block.valid;
            s1_ctl_reg.last  <= sub_block.last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_sm_reg <= sub_block.scale_min;
            s1_gs_reg <= sub_block.group_sum;
        end
    end

    q2k_merge #(
        .LANES  (LANES),
        .PART_W (PART_W)
    ) u_merge (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .part      (part),
        .scale_min (s1_sm_reg),
        .group_sum (s1_gs_reg),
        .ctl_in    (s1_ctl_reg),
        .scaled    (scaled),
        .min_prod  (min_prod),
        .ctl_out   (s2_ctl)
    );

    q2k_accum u_accum (
        .clk      (clk),
        .rst_n    (rst_n),
        .scaled   (scaled),
        .min_prod (min_prod),
        .ctl      (s2_ctl),
        .adv      (adv),
        .result   (result)
    );
endmodule

// ===== src/q2k_lane.sv =====
module q2k_lane #(
    parameter int EPL = 4
) (
    input  logic                                              clk,
    input  logic                                              en,
    input  logic [EPL*q2k_pkg::WCODE_W-1:0]                   weights,
    input  logic [EPL*q2k_pkg::ACT_W-1:0]                     acts,
    output logic signed [q2k_pkg::ACT_W+1+$clog2(EPL):0]      part
);
    import q2k_pkg::*;

    localparam int PART_W = ACT_W + 2 + $clog2(EPL);

    logic signed [PART_W-1:0] part_reg;
    logic signed [PART_W-1:0] part_next;

    always_comb
    begin
        logic signed [PART_W-1:0] w_ext;
        logic signed [PART_W-1:0] a_ext;
        part_next = '0;
        for (int i = 0; i < EPL; i++)
        begin
            w_ext = PART_W'($signed({1'b0, weights[WCODE_W*i +: WCODE_W]}));
            a_ext = PART_W'($signed(acts[ACT_W*i +: ACT_W]));
            part_next = part_next + w_ext * a_ext;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            part_reg <= part_next;
        end
    end

    assign part = part_reg;
endmodule

// ===== src/q2k_merge.sv =====
module q2k_merge #(
    parameter int LANES  = 4,
    parameter int PART_W = 12
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 en,
    input  logic signed [PART_W-1:0]             part [LANES],
    input  logic [q2k_pkg::SM_W-1:0]             scale_min,
    input  logic signed [q2k_pkg::GS_W-1:0]      group_sum,
    input  q2k_pkg::q2k_ctl_t                    ctl_in,
    output logic signed [q2k_pkg::SCALED_W-1:0]  scaled,
    output logic signed [q2k_pkg::MINP_W-1:0]    min_prod,
    output q2k_pkg::q2k_ctl_t                    ctl_out
);
    import q2k_pkg::*;

    logic signed [DOT_W-1:0]    dot;
    logic signed [SCALED_W-1:0] scaled_next;
    logic signed [MINP_W-1:0]   min_prod_next;
    logic signed [SCALED_W-1:0] scaled_reg;
    logic signed [MINP_W-1:0]   min_prod_reg;
    q2k_ctl_t                   ctl_reg;

    // adder across the lanes, then one multiply per term
    always_comb
    begin
        dot = '0;
        for (int l = 0; l < LANES; l++)
        begin
            dot = dot + DOT_W'(part[l]);
        end
        scaled_next = SCALED_W'($signed({1'b0, scale_min[NIB_W-1:0]}))
                      * SCALED_W'(dot);
        min_prod_next = MINP_W'($signed({1'b0, scale_min[SM_W-1:NIB_W]}))
                        * MINP_W'(group_sum);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            scaled_reg   <= scaled_next;
            min_prod_reg <= min_prod_next;
        end
    end

    assign scaled   = scaled_reg;
    assign min_prod = min_prod_reg;
    assign ctl_out  = ctl_reg;
endmodule

// ===== src/q2k_accum.sv =====
module q2k_accum (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic signed [q2k_pkg::SCALED_W-1:0]  scaled,
    input  logic signed [q2k_pkg::MINP_W-1:0]    min_prod,
    input  q2k_pkg::q2k_ctl_t                    ctl,
    output logic                                 adv,
    q2k_out_if.source                            result
);
    import q2k_pkg::*;

    logic signed [MAIN_W-1:0] main_acc_reg;
    logic signed [MAIN_W-1:0] main_acc_next;
    logic signed [MIN_W-1:0]  min_acc_reg;
    logic signed [MIN_W-1:0]  min_acc_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [MAIN_W-1:0] main_sum_reg;
    logic signed [MIN_W-1:0]  min_sum_reg;
    logic signed [MAIN_W:0]   main_wide;
    logic signed [MIN_W:0]    min_wide;
    logic signed [MAIN_W-1:0] main_sat;
    logic signed [MIN_W-1:0]  min_sat;
    logic                     emit;

    // a last beat waits here only while the previous sums are still unread
    assign adv  = !(ctl.valid && ctl.last && out_valid_reg && !result.ready);
    assign emit = adv && ctl.valid && ctl.last;

    always_comb
    begin
        main_wide = (MAIN_W + 1)'(main_acc_reg) + (MAIN_W + 1)'(scaled);
        min_wide  = (MIN_W + 1)'(min_acc_reg) + (MIN_W + 1)'(min_prod);

        // saturate when the carry disagrees with the sign
        if (main_wide[MAIN_W] != main_wide[MAIN_W-1])
        begin
            main_sat = {main_wide[MAIN_W], {(MAIN_W - 1){!main_wide[MAIN_W]}}};
        end
        else
        begin
            main_sat = main_wide[MAIN_W-1:0];
        end
        if (min_wide[MIN_W] != min_wide[MIN_W-1])
        begin
            min_sat = {min_wide[MIN_W], {(MIN_W - 1){!min_wide[MIN_W]}}};
        end
        else
        begin
            min_sat = min_wide[MIN_W-1:0];
        end

        main_acc_next = main_acc_reg;
        min_acc_next  = min_acc_reg;
        if (adv && ctl.valid)
        begin
            main_acc_next = ctl.last ? '0 : main_sat;
            min_acc_next  = ctl.last ? '0 : min_sat;
        end

        out_valid_next = out_valid_reg && !result.ready;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_acc_reg  <= '0;
            min_acc_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            main_acc_reg  <= main_acc_next;
            min_acc_reg   <= min_acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            main_sum_reg <= main_sat;
            min_sum_reg  <= min_sat;
        end
    end

    assign result.valid    = out_valid_reg;
    assign result.main_sum = main_sum_reg;
    assign result.min_sum  = min_sum_reg;

    a_clear_after_emit: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (main_acc_reg == '0) && (min_acc_reg == '0) && out_valid_reg)
        else $error("accumulators not cleared after a result");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> !(out_valid_reg && !result.ready))
        else $error("result loaded over an unread one");

    a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> (main_acc_reg == $past(main_acc_reg))
                 && (min_acc_reg == $past(min_acc_reg)))
        else $error("accumulator moved while stalled");
endmodule
